// ===== src/sepe_pkg.sv =====
// Shared constants and types for the Sampson epipolar error block.
package sepe_pkg;

  localparam int NUM_ROWS  = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_E_ROW0 = 2'd0,
    CFG_E_ROW1 = 2'd1,
    CFG_E_ROW2 = 2'd2
  } cfg_idx_e;

endpackage

// ===== src/sepe_if.sv =====
// Valid/ready channel interfaces for correspondences and error results.
interface sepe_in_if #(
  parameter int COORD_BITS = 18
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_u;
  logic signed [COORD_BITS-1:0] first_v;
  logic signed [COORD_BITS-1:0] second_u;
  logic signed [COORD_BITS-1:0] second_v;

  modport source (output valid, first_u, first_v, second_u, second_v, input ready);
  modport sink   (input valid, first_u, first_v, second_u, second_v, output ready);
endinterface

interface sepe_out_if #(
  parameter int ERROR_BITS = 40
) ();
  logic                  valid;
  logic                  ready;
  logic [ERROR_BITS-1:0] squared_error;
  logic                  saturated;
  logic                  degenerate;

  modport source (output valid, squared_error, saturated, degenerate, input ready);
  modport sink   (input valid, squared_error, saturated, degenerate, output ready);
endinterface

// ===== src/sepe_front.sv =====
// Front pipeline: matrix registers, E*x1, E^T*x2, residual and gradient norm.
module sepe_front #(
  parameter int COORD_BITS = 18,
  parameter int COEF_BITS  = 18,
  localparam int FRAC = COORD_BITS - 4,
  localparam int PW   = COEF_BITS + COORD_BITS,
  localparam int AW   = PW + 2,
  localparam int CW   = AW + COORD_BITS + 2,
  localparam int DW   = 2 * AW + 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sepe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [3*COEF_BITS-1:0]           cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_BITS-1:0]     first_u_i,
  input  logic signed [COORD_BITS-1:0]     first_v_i,
  input  logic signed [COORD_BITS-1:0]     second_u_i,
  input  logic signed [COORD_BITS-1:0]     second_v_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [CW-1:0]             c_o,
  output logic [DW-1:0]                    d_o
);
  import sepe_pkg::*;

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;

  logic [3*COEF_BITS-1:0] row_q [NUM_ROWS];
  logic signed [COEF_BITS-1:0] e [NUM_ROWS][NUM_ROWS];

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [PW-1:0]         pa_q [NUM_ROWS][2];
  logic signed [PW-1:0]         pb_q [2][2];
  logic signed [COEF_BITS-1:0]  ea2_q [NUM_ROWS];
  logic signed [COEF_BITS-1:0]  eb2_q [2];
  logic signed [COORD_BITS-1:0] q0_1_q, q1_1_q, q0_2_q, q1_2_q;

  logic signed [AW-1:0] a_q [NUM_ROWS];
  logic signed [AW-1:0] b_q [2];

  logic signed [CW-1:0] ct_q [NUM_ROWS];
  logic [2*AH-1:0]      hh_q [4];
  logic [AH+AL-1:0]     hl_q [4];
  logic [2*AL-1:0]      ll_q [4];
  logic [AW-1:0]        mag [4];
  logic signed [AW-1:0] sq_src [4];

  logic signed [CW-1:0] c_q;
  logic [DW-1:0]        d_q;

  // Config rows; out-of-range index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) row_q[r] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_E_ROW0: row_q[0] <= cfg_data_i;
        CFG_E_ROW1: row_q[1] <= cfg_data_i;
        CFG_E_ROW2: row_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        e[r][c] = $signed(row_q[r][c*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  assign en         = !v4_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_comb begin
    sq_src[0] = a_q[0];
    sq_src[1] = a_q[1];
    sq_src[2] = b_q[0];
    sq_src[3] = b_q[1];
    for (int k = 0; k < 4; k++) begin
      mag[k] = $unsigned(sq_src[k]);
      if (sq_src[k][AW-1]) mag[k] = ~mag[k] + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // products with the matrix entries
      for (int r = 0; r < NUM_ROWS; r++) begin
        pa_q[r][0] <= e[r][0] * first_u_i;
        pa_q[r][1] <= e[r][1] * first_v_i;
        ea2_q[r]   <= e[r][2];
      end
      for (int i = 0; i < 2; i++) begin
        pb_q[i][0] <= e[0][i] * second_u_i;
        pb_q[i][1] <= e[1][i] * second_v_i;
        eb2_q[i]   <= e[2][i];
      end
      q0_1_q <= second_u_i;
      q1_1_q <= second_v_i;

      // a = E*x1, b = E^T*x2 (homogeneous one is a shift)
      for (int r = 0; r < NUM_ROWS; r++) begin
        a_q[r] <= AW'(pa_q[r][0]) + AW'(pa_q[r][1]) + (AW'(ea2_q[r]) <<< FRAC);
      end
      for (int i = 0; i < 2; i++) begin
        b_q[i] <= AW'(pb_q[i][0]) + AW'(pb_q[i][1]) + (AW'(eb2_q[i]) <<< FRAC);
      end
      q0_2_q <= q0_1_q;
      q1_2_q <= q1_1_q;

      // residual terms and split squares
      ct_q[0] <= a_q[0] * q0_2_q;
      ct_q[1] <= a_q[1] * q1_2_q;
      ct_q[2] <= CW'(a_q[2]) <<< FRAC;
      for (int k = 0; k < 4; k++) begin
        hh_q[k] <= mag[k][AW-1:AL] * mag[k][AW-1:AL];
        hl_q[k] <= mag[k][AW-1:AL] * mag[k][AL-1:0];
        ll_q[k] <= mag[k][AL-1:0] * mag[k][AL-1:0];
      end

      c_q <= ct_q[0] + ct_q[1] + ct_q[2];
      d_q <= ((DW'(hh_q[0]) << (2*AL)) + (DW'(hl_q[0]) << (AL+1)) + DW'(ll_q[0]))
           + ((DW'(hh_q[1]) << (2*AL)) + (DW'(hl_q[1]) << (AL+1)) + DW'(ll_q[1]))
           + ((DW'(hh_q[2]) << (2*AL)) + (DW'(hl_q[2]) << (AL+1)) + DW'(ll_q[2]))
           + ((DW'(hh_q[3]) << (2*AL)) + (DW'(hl_q[3]) << (AL+1)) + DW'(ll_q[3]));
    end
  end

  assign out_valid_o = v4_q;
  assign c_o         = c_q;
  assign d_o         = d_q;
endmodule

// ===== src/sepe_queue.sv =====
// Small register FIFO between the front and back pipelines.
module sepe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end
endmodule

// ===== src/sepe_back.sv =====
// Back pipeline: C squared, scaling and a one-bit-per-stage restoring divider.
module sepe_back #(
  parameter int COORD_BITS = 18,
  parameter int COEF_BITS  = 18,
  parameter int ERROR_BITS = 40,
  localparam int AW = COEF_BITS + COORD_BITS + 2,
  localparam int CW = AW + COORD_BITS + 2,
  localparam int DW = 2 * AW + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [CW-1:0]  c_i,
  input  logic [DW-1:0]         d_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ERROR_BITS-1:0] err_o,
  output logic                  sat_o,
  output logic                  deg_o
);
  localparam int FRAC = COORD_BITS - 4;
  localparam int SH   = ERROR_BITS - 8 - 2 * FRAC;
  localparam int SHN  = (SH > 0) ? SH : 0;
  localparam int SHD  = (SH < 0) ? -SH : 0;
  localparam int NW   = 2 * CW + SHN;
  localparam int DSW  = DW + SHD;
  localparam int RW   = (NW > DSW + ERROR_BITS) ? NW : DSW + ERROR_BITS;
  localparam int CL   = CW / 2;
  localparam int CH   = CW - CL;
  localparam int NS   = ERROR_BITS + 1;

  logic en;
  logic [CW-1:0] cmag;

  logic             v0_q, v1_q;
  logic [2*CH-1:0]  chh_q;
  logic [CH+CL-1:0] chl_q;
  logic [2*CL-1:0]  cll_q;
  logic [DSW-1:0]   den0_q, den1_q;
  logic             deg0_q, deg1_q;
  logic [NW-1:0]    num1_q;

  logic                  dv_q   [NS];
  logic [RW-1:0]         rem_q  [NS];
  logic [DSW-1:0]        dden_q [NS];
  logic [ERROR_BITS-1:0] quo_q  [NS];
  logic                  sat_q  [NS];
  logic                  ddeg_q [NS];

  assign en         = !dv_q[NS-1] || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    cmag = $unsigned(c_i);
    if (c_i[CW-1]) cmag = ~cmag + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      for (int j = 0; j < NS; j++) dv_q[j] <= 1'b0;
    end else if (en) begin
      v0_q    <= in_valid_i;
      v1_q    <= v0_q;
      dv_q[0] <= v1_q;
      for (int j = 1; j < NS; j++) dv_q[j] <= dv_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chh_q  <= cmag[CW-1:CL] * cmag[CW-1:CL];
      chl_q  <= cmag[CW-1:CL] * cmag[CL-1:0];
      cll_q  <= cmag[CL-1:0] * cmag[CL-1:0];
      den0_q <= DSW'(d_i) << SHD;
      deg0_q <= d_i == '0;

      num1_q <= ((NW'(chh_q) << (2*CL)) + (NW'(chl_q) << (CL+1)) + NW'(cll_q)) << SHN;
      den1_q <= den0_q;
      deg1_q <= deg0_q;

      // range check against the full quotient width
      rem_q[0]  <= RW'(num1_q);
      dden_q[0] <= den1_q;
      quo_q[0]  <= '0;
      sat_q[0]  <= RW'(num1_q) >= (RW'(den1_q) << ERROR_BITS);
      ddeg_q[0] <= deg1_q;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_div
    localparam int K = ERROR_BITS - j;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = RW'(dden_q[j-1]) << K;
    assign take  = rem_q[j-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[j]  <= take ? rem_q[j-1] - trial : rem_q[j-1];
        quo_q[j]  <= quo_q[j-1] | (take ? (ERROR_BITS'(1) << K) : '0);
        dden_q[j] <= dden_q[j-1];
        sat_q[j]  <= sat_q[j-1];
        ddeg_q[j] <= ddeg_q[j-1];
      end
    end
  end

  assign out_valid_o = dv_q[NS-1];
  assign deg_o       = ddeg_q[NS-1];
  assign sat_o       = sat_q[NS-1] && !ddeg_q[NS-1];
  assign err_o       = (ddeg_q[NS-1] || sat_q[NS-1]) ? '1 : quo_q[NS-1];
endmodule

// ===== src/sampson_epipolar_error_top.sv =====
// Top level of the Sampson epipolar error scorer.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid / ready    first_u, first_v, second_u, second_v (Q3.14)
//   out_ch    out  valid / ready    squared_error (Q8.32), saturated, degenerate
//   cfg       in   cfg_we_i         cfg_idx_i selects e_row0..2, cfg_data_i
//
// One transaction per cycle sustained while out_ch.ready stays high; every stage is a single register step.
// A result passes the front pipeline, the queue and then the back pipeline, whose
// length is set by the one-bit-per-stage divider.
// Reset clears the matrix rows to zero and empties every pipeline and the queue.
// An output stall freezes only the back pipeline; the front keeps filling the
// queue and holds in_ch.ready low only once the queue is full.
module sampson_epipolar_error_top #(
  parameter int COORD_BITS = 18,
  parameter int COEF_BITS  = 18,
  parameter int ERROR_BITS = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sepe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [3*COEF_BITS-1:0]         cfg_data_i,
  sepe_in_if.sink                        in_ch,
  sepe_out_if.source                     out_ch
);
  import sepe_pkg::*;

  localparam int AW    = COEF_BITS + COORD_BITS + 2;
  localparam int CW    = AW + COORD_BITS + 2;
  localparam int DW    = 2 * AW + 2;
  localparam int QW    = CW + DW;
  localparam int QDEPTH = 4;

  logic                 f_valid, f_ready;
  logic signed [CW-1:0] f_c;
  logic [DW-1:0]        f_d;
  logic                 b_valid, b_ready;
  logic [QW-1:0]        b_data;

  sepe_front #(
    .COORD_BITS(COORD_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .first_u_i  (in_ch.first_u),
    .first_v_i  (in_ch.first_v),
    .second_u_i (in_ch.second_u),
    .second_v_i (in_ch.second_v),
    .out_valid_o(f_valid),
    .out_ready_i(f_ready),
    .c_o        (f_c),
    .d_o        (f_d)
  );

  // hold residual and norm until the back pipeline can take them
  sepe_queue #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i ({f_c, f_d}),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready),
    .pop_data_o  (b_data)
  );

  sepe_back #(
    .COORD_BITS(COORD_BITS),
    .COEF_BITS (COEF_BITS),
    .ERROR_BITS(ERROR_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (b_valid),
    .in_ready_o (b_ready),
    .c_i        ($signed(b_data[QW-1:DW])),
    .d_i        (b_data[DW-1:0]),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .err_o      (out_ch.squared_error),
    .sat_o      (out_ch.saturated),
    .deg_o      (out_ch.degenerate)
  );
endmodule

// ===== src/sepe_checker.sv =====
// Port-level assertions for the Sampson error block, bound to the top level.
module sepe_checker #(
  parameter int ERROR_BITS = 40
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [ERROR_BITS-1:0] squared_error_i,
  input logic                  saturated_i,
  input logic                  degenerate_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(saturated_i && degenerate_i))
    else $error("saturated and degenerate both set");

  a_flag_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (saturated_i || degenerate_i) |-> squared_error_i == {ERROR_BITS{1'b1}})
    else $error("flagged result not at maximum");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");
endmodule

bind sampson_epipolar_error_top sepe_checker #(.ERROR_BITS(ERROR_BITS)) u_sepe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .squared_error_i(out_ch.squared_error),
  .saturated_i    (out_ch.saturated),
  .degenerate_i   (out_ch.degenerate)
);
